[rtl/core/bucket_priority_queue_assert.svh]
// Assertion macros used by the checker file.
`ifndef BUCKET_PRIORITY_QUEUE_ASSERT_SVH
`define BUCKET_PRIORITY_QUEUE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bpq_pkg.sv]
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared constants and types of the bucket priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int NUM_KEYS  = 64;
    localparam int MAX_ELEMS = 256;
    localparam int KEY_W     = $clog2(NUM_KEYS);
    localparam int ID_W      = $clog2(MAX_ELEMS);
    localparam int MARK_W    = KEY_W + 1;
    localparam int CNT_W     = ID_W + 1;
    localparam int SLOT_AW   = KEY_W + ID_W;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_CONFLICT = 2'd3;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;       // capture input transaction
        logic rd_elem;    // read element tables for captured id
        logic rd_len;     // read list length at the scan / element key
        logic scan_step;  // advance pop scan pointer
        logic rd_last;    // read the last slot of the selected list
        logic detach;     // move last entry into the freed slot
        logic rd_len_new; // read length of new key list
        logic append;     // append element to new key list
        logic pop_commit; // remove popped entry
        logic finish;     // present result with given status
        logic [1:0] fin_status;
    } bpq_cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       key_bad;
        logic       queued;
        logic       total_zero;
        logic       scan_end;
        logic       len_zero;
    } bpq_stat_t;

endpackage

[rtl/core/bpq_datapath.sv]
// ----------------------------------------------------------------------------
// bpq_datapath
// Slot memory, list and element tables, scan pointer and result registers.
// ----------------------------------------------------------------------------
module bpq_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpq_pkg::bpq_cmd_t     cmd,
    output bpq_pkg::bpq_stat_t    stat,
    input  logic [1:0]            op,
    input  logic [7:0]            elem_id,
    input  logic [5:0]            new_key,
    output logic [7:0]            out_elem,
    output logic [5:0]            out_key,
    output logic [1:0]            status,
    output logic [8:0]            count
);
    import bpq_pkg::*;

    // Storage
    logic [ID_W-1:0]  slot_mem [NUM_KEYS*MAX_ELEMS];
    logic [CNT_W-1:0] len_mem  [NUM_KEYS];
    logic [KEY_W-1:0] key_mem  [MAX_ELEMS];
    logic [ID_W-1:0]  pos_mem  [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] queued_reg;
    logic [MARK_W-1:0] mark_reg;
    logic [CNT_W-1:0]  total_reg;

    // Length entries count as zero until their list is first appended to
    logic [NUM_KEYS-1:0] len_vld_reg;

    // Captured transaction and working registers
    logic [1:0]       op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [KEY_W-1:0] nkey_reg;
    logic [KEY_W-1:0] okey_reg;
    logic [ID_W-1:0]  opos_reg;
    logic [CNT_W-1:0] len_reg;
    logic [MARK_W-1:0] scan_reg;
    logic [ID_W-1:0]  last_id_reg;
    logic [7:0]       res_elem_reg;
    logic [5:0]       res_key_reg;
    logic [1:0]       res_st_reg;

    // Length table read address: scan pointer on pop, old key on update
    logic [KEY_W-1:0] len_addr;
    logic [ID_W-1:0]  last_idx;
    always_comb
    begin
        len_addr = (op_reg == OP_POP) ? scan_reg[KEY_W-1:0] : okey_reg;
        last_idx = len_reg[ID_W-1:0] - 1'b1;
    end

    assign stat.op         = op_reg;
    assign stat.key_bad    = ({1'b0, nkey_reg} >= MARK_W'(NUM_KEYS));
    assign stat.queued     = queued_reg[id_reg];
    assign stat.total_zero = (total_reg == '0);
    assign stat.scan_end   = (scan_reg >= MARK_W'(NUM_KEYS));
    assign stat.len_zero   = (len_reg == '0);

    // Memories and working registers (no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.rd_elem)
        begin
            okey_reg <= key_mem[id_reg];
            opos_reg <= pos_mem[id_reg];
        end
        if (cmd.rd_last)
            last_id_reg <= slot_mem[{len_addr, last_idx}];
        if (cmd.detach)
        begin
            slot_mem[{okey_reg, opos_reg}] <= last_id_reg;
            pos_mem[last_id_reg] <= opos_reg;
        end
        if (cmd.append)
        begin
            slot_mem[{nkey_reg, len_reg[ID_W-1:0]}] <= id_reg;
            key_mem[id_reg] <= nkey_reg;
            pos_mem[id_reg] <= len_reg[ID_W-1:0];
        end
        if (cmd.rd_len)
            len_reg <= len_vld_reg[len_addr] ? len_mem[len_addr] : '0;
        else if (cmd.rd_len_new)
            len_reg <= len_vld_reg[nkey_reg] ? len_mem[nkey_reg] : '0;
        if (cmd.detach)
            len_mem[okey_reg] <= {1'b0, last_idx};
        if (cmd.append)
            len_mem[nkey_reg] <= len_reg + 1'b1;
        if (cmd.pop_commit)
            len_mem[scan_reg[KEY_W-1:0]] <= {1'b0, last_idx};
        if (cmd.load)
        begin
            op_reg   <= op;
            id_reg   <= elem_id;
            nkey_reg <= new_key;
        end
        if (cmd.finish)
        begin
            res_st_reg <= cmd.fin_status;
            if (cmd.pop_commit)
            begin
                res_elem_reg <= last_id_reg;
                res_key_reg  <= scan_reg[KEY_W-1:0];
            end
            else
            begin
                res_elem_reg <= id_reg;
                res_key_reg  <= '0;
            end
        end
    end

    // Control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg  <= '0;
            mark_reg    <= MARK_W'(NUM_KEYS);
            total_reg   <= '0;
            scan_reg    <= '0;
            len_vld_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                scan_reg <= mark_reg;
            else if (cmd.scan_step)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.detach)
            begin
                queued_reg[id_reg] <= 1'b0;
                total_reg <= total_reg - 1'b1;
                if (total_reg == CNT_W'(1))
                    mark_reg <= MARK_W'(NUM_KEYS);
            end
            if (cmd.append)
            begin
                queued_reg[id_reg]    <= 1'b1;
                len_vld_reg[nkey_reg] <= 1'b1;
                total_reg <= (cmd.detach ? total_reg : total_reg + 1'b1);
                if ({1'b0, nkey_reg} < mark_reg)
                    mark_reg <= {1'b0, nkey_reg};
            end
            if (cmd.pop_commit)
            begin
                queued_reg[last_id_reg] <= 1'b0;
                total_reg <= total_reg - 1'b1;
                mark_reg  <= scan_reg;
            end
        end
    end

    assign out_elem = res_elem_reg;
    assign out_key  = res_key_reg;
    assign status   = res_st_reg;
    assign count    = total_reg;

endmodule

[rtl/core/bpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bpq_ctrl
// Sequencer for push, pop and update, plus the output handshake.
// ----------------------------------------------------------------------------
module bpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  bpq_pkg::bpq_stat_t stat,
    output bpq_pkg::bpq_cmd_t  cmd
);
    import bpq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_SCHK   = 4'd3;
    localparam logic [3:0] S_PLAST  = 4'd4;
    localparam logic [3:0] S_PCOM   = 4'd5;
    localparam logic [3:0] S_ULEN   = 4'd6;
    localparam logic [3:0] S_ULAST  = 4'd7;
    localparam logic [3:0] S_UDET   = 4'd8;
    localparam logic [3:0] S_NLEN   = 4'd9;
    localparam logic [3:0] S_APP    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_ELEM   = 4'd12;

    logic [3:0] state_reg, state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_ELEM;
                end
            end
            S_ELEM:
            begin
                cmd.rd_elem = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.op == OP_POP)
                begin
                    if (stat.total_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = ST_EMPTY;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SCAN;
                end
                else if (stat.op == OP_PUSH || stat.op == OP_UPDATE)
                begin
                    if (stat.key_bad)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = ST_RANGE;
                        state_next = S_OUT;
                    end
                    else if ((stat.op == OP_PUSH) == stat.queued)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = ST_CONFLICT;
                        state_next = S_OUT;
                    end
                    else if (stat.op == OP_PUSH)
                        state_next = S_NLEN;
                    else
                        state_next = S_ULEN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next = S_OUT;
                end
            end
            // Pop: read length at scan pointer
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_EMPTY;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_len = 1'b1;
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (stat.len_zero)
                begin
                    cmd.scan_step = 1'b1;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_PLAST;
            end
            S_PLAST:
            begin
                cmd.rd_last = 1'b1;
                state_next = S_PCOM;
            end
            S_PCOM:
            begin
                cmd.pop_commit = 1'b1;
                cmd.finish = 1'b1;
                cmd.fin_status = ST_OK;
                state_next = S_OUT;
            end
            // Update: detach from old list
            S_ULEN:
            begin
                cmd.rd_len = 1'b1;
                state_next = S_ULAST;
            end
            S_ULAST:
            begin
                cmd.rd_last = 1'b1;
                state_next = S_UDET;
            end
            S_UDET:
            begin
                cmd.detach = 1'b1;
                state_next = S_NLEN;
            end
            S_NLEN:
            begin
                cmd.rd_len_new = 1'b1;
                state_next = S_APP;
            end
            S_APP:
            begin
                cmd.append = 1'b1;
                cmd.finish = 1'b1;
                cmd.fin_status = ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/bucket_priority_queue.sv]
// Throughput: one transaction at a time; input stalls from acceptance until the
// result is taken and the sequencer is back in idle.
// Reset: asynchronous active low; queue empty, lowest-key mark at key count,
// list lengths read as zero until first written, no clearing pass.
// ----------------------------------------------------------------------------
// bucket_priority_queue
// Integer-key bucket priority queue with push, pop-minimum and update.
// ----------------------------------------------------------------------------
module bucket_priority_queue (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] elem_id,
    input  logic [5:0] new_key,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_elem,
    output logic [5:0] out_key,
    output logic [1:0] status,
    output logic [8:0] count
);
    import bpq_pkg::*;

    bpq_cmd_t  cmd;
    bpq_stat_t stat;

    bpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .op       (op),
        .elem_id  (elem_id),
        .new_key  (new_key),
        .out_elem (out_elem),
        .out_key  (out_key),
        .status   (status),
        .count    (count)
    );

endmodule

[rtl/core/bpq_checker.sv]
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks on the queue's transactions over time.
// ----------------------------------------------------------------------------
`include "bucket_priority_queue_assert.svh"

module bpq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_elem,
    input logic [1:0] status,
    input logic [8:0] count
);
    // Input is blocked while a result is pending
    `BPQ_ASSERT_IMP(a_stall_out, clk, rst_n, out_valid, in_stall, "input taken with result pending")
    // Accepted input leads to busy state
    `BPQ_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "no busy after accept")
    // Count never exceeds capacity while a result is presented
    `BPQ_ASSERT_IMP(a_cnt, clk, rst_n, out_valid, count <= 9'd256, "count out of range")
    // Stalled result holds
    `BPQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(out_elem), "result changed under stall")
endmodule

bind bucket_priority_queue bpq_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_elem  (out_elem),
    .status    (status),
    .count     (count)
);

[tb/tb_bucket_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_bucket_priority_queue
// Self-checking bench for the bucket priority queue: a behavioral copy of
// the queue predicts status, popped element, key and count per transaction.
// ----------------------------------------------------------------------------
module tb_bucket_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import bpq_pkg::*;

    typedef struct packed {
        logic [7:0] elem;
        logic [5:0] key;
        logic [1:0] st;
        logic [8:0] cnt;
    } pq_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] op = OP_PUSH;
    logic [7:0] elem_id = '0;
    logic [5:0] new_key = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_elem;
    logic [5:0] out_key;
    logic [1:0] status;
    logic [8:0] count;

    // Predicted queue contents
    logic [7:0] bucket_slots [NUM_KEYS][MAX_ELEMS];
    int         bucket_len [NUM_KEYS];
    logic [5:0] id_key [MAX_ELEMS];
    int         id_slot [MAX_ELEMS];
    bit         id_queued [MAX_ELEMS];
    int         min_mark;
    int         queued_total;

    pq_result_t expected_results [$];
    int         mismatch_count = 0;
    bit         allow_stall = 1'b1;

    always #6 clk = ~clk;

    bucket_priority_queue i_dut (.*);

    // Queue model
    function automatic void bucket_append(int k, int id);
        id_slot[id] = bucket_len[k];
        bucket_slots[k][bucket_len[k]] = id[7:0];
        bucket_len[k]++;
        id_key[id] = k[5:0];
        id_queued[id] = 1'b1;
        queued_total++;
        if (k < min_mark) min_mark = k;
    endfunction

    function automatic void bucket_detach(int id);
        int k;
        int pos;
        logic [7:0] moved;
        k = id_key[id];
        pos = id_slot[id];
        moved = bucket_slots[k][bucket_len[k] - 1];
        bucket_slots[k][pos] = moved;
        id_slot[moved] = pos;
        bucket_len[k]--;
        id_queued[id] = 1'b0;
        queued_total--;
        if (queued_total == 0) min_mark = NUM_KEYS;
    endfunction

    function automatic pq_result_t predict_queue_op(logic [1:0] o, logic [7:0] id,
                                                    logic [5:0] k);
        pq_result_t r;
        int s;
        logic [7:0] e;
        r = '{elem: id, key: '0, st: ST_OK, cnt: '0};
        if (o == OP_PUSH || o == OP_UPDATE) begin
            if (k >= NUM_KEYS) r.st = ST_RANGE;
            else if (o == OP_PUSH) begin
                if (id_queued[id]) r.st = ST_CONFLICT;
                else bucket_append(k, id);
            end else begin
                if (!id_queued[id]) r.st = ST_CONFLICT;
                else begin
                    bucket_detach(id);
                    bucket_append(k, id);
                end
            end
        end else if (o == OP_POP) begin
            s = min_mark;
            while (s < NUM_KEYS && bucket_len[s] == 0) s++;
            if (queued_total == 0 || s >= NUM_KEYS) r.st = ST_EMPTY;
            else begin
                bucket_len[s]--;
                e = bucket_slots[s][bucket_len[s]];
                min_mark = s;
                id_queued[e] = 1'b0;
                queued_total--;
                r.elem = e;
                r.key = s[5:0];
            end
        end
        r.cnt = queued_total[8:0];
        return r;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Send one transaction and record its prediction on acceptance
    task automatic send_item(logic [1:0] o, logic [7:0] id, logic [5:0] k,
                             bit gaps = 1'b1);
        int g;
        g = gaps ? random_gap() : 0;
        // a wait always comes first: the previous transaction drops valid on its
        // accepting edge, and the queue is busy right after it anyway
        repeat (g + 1) @(posedge clk);
        in_valid <= 1'b1;
        op <= o;
        elem_id <= id;
        new_key <= k;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(predict_queue_op(o, id, k));
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Directed: extremes of fields, every op, and the empty and conflict error paths
    task automatic test_directed();
        send_item(OP_POP, 8'd0, 6'd0);
        send_item(OP_UPDATE, 8'd5, 6'd3);
        send_item(OP_PUSH, 8'd255, 6'd63);
        send_item(OP_PUSH, 8'd0, 6'd0);
        send_item(OP_PUSH, 8'd0, 6'd7);
        send_item(OP_PUSH, 8'd17, 6'd0);
        send_item(OP_PUSH, 8'd42, 6'd0);
        send_item(OP_UPDATE, 8'd0, 6'd0);
        send_item(OP_UPDATE, 8'd17, 6'd40);
        send_item(OP_UNUSED, 8'd170, 6'd21);
        send_item(OP_POP, 8'd85, 6'd42);
        send_item(OP_POP, 8'd0, 6'd0);
        send_item(OP_POP, 8'd0, 6'd0);
        send_item(OP_POP, 8'd0, 6'd0);
        send_item(OP_POP, 8'd0, 6'd0);
        send_item(OP_POP, 8'd0, 6'd0);
        // queue emptied by update resets the mark
        send_item(OP_PUSH, 8'd9, 6'd2);
        send_item(OP_UPDATE, 8'd9, 6'd50);
        send_item(OP_PUSH, 8'd10, 6'd60);
        send_item(OP_POP, 8'd0, 6'd0);
        send_item(OP_POP, 8'd0, 6'd0);
        wait_drained();
    endtask

    // Random mix biased toward pushes/updates that name queued elements
    task automatic test_random(int n);
        int sel;
        logic [7:0] id;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            id = 8'($urandom_range(0, 255));
            if (sel < 40) begin
                if (queued_total > 0 && $urandom_range(0, 3) != 0)
                    while (!id_queued[id]) id = 8'($urandom_range(0, 255));
                send_item(sel < 34 ? OP_PUSH : OP_UPDATE, id, 6'($urandom_range(0, 63)));
            end else if (sel < 65) begin
                if (queued_total > 0 && $urandom_range(0, 5) != 0)
                    while (!id_queued[id]) id = 8'($urandom_range(0, 255));
                send_item(OP_UPDATE, id, 6'($urandom_range(0, 63)));
            end else if (sel < 97) send_item(OP_POP, id, 6'($urandom_range(0, 63)));
            else send_item(OP_UNUSED, id, 6'($urandom_range(0, 63)));
            if (i == n / 2) wait_drained();
        end
    endtask

    // Back-to-back traffic with the receiver never stalling
    task automatic test_burst(int n);
        allow_stall = 1'b0;
        for (int i = 0; i < n; i++)
            send_item($urandom_range(0, 1) ? OP_PUSH : OP_POP,
                      8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), 1'b0);
        wait_drained();
        allow_stall = 1'b1;
    endtask

    // Receiver stall pattern
    always @(posedge clk) begin
        if (!allow_stall) out_stall <= 1'b0;
        else if ($urandom_range(0, 29) == 0) out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 5) == 0) out_stall <= 1'b0;
        else if (!out_stall) out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Result checker
    always @(posedge clk) begin
        pq_result_t got;
        pq_result_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            got = '{elem: out_elem, key: out_key, st: status, cnt: count};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected transaction %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) bucket_len[k] = 0;
        for (int e = 0; e < MAX_ELEMS; e++) id_queued[e] = 1'b0;
        min_mark = NUM_KEYS;
        queued_total = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_burst(80);
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bpq_pkg.sv
rtl/core/bpq_datapath.sv
rtl/core/bpq_ctrl.sv
rtl/core/bucket_priority_queue.sv
rtl/core/bpq_checker.sv
tb/tb_bucket_priority_queue.sv
